// ----- src/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk, off while rst_n is low.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds, off while rst_n is low.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- src/mppr_pkg.sv -----
`default_nettype none

package mppr_pkg;

  localparam int SAMPLE_BITS     = 24;
  localparam int PHASE_FRAC_BITS = 16;
  localparam int RATE_BITS       = PHASE_FRAC_BITS + 4;
  localparam int MAX_OUT         = 8;
  localparam int CNT_BITS        = $clog2(MAX_OUT + 1);

  // Phase constants in Q4.16
  localparam logic [RATE_BITS-1:0] PHASE_ONE     = RATE_BITS'(1) << PHASE_FRAC_BITS;
  localparam logic [RATE_BITS-1:0] STEP_MIN      = PHASE_ONE >> 3;
  localparam logic [RATE_BITS-1:0] STEP_MAX      = RATE_BITS'(12) << PHASE_FRAC_BITS;
  localparam logic [RATE_BITS-1:0] PHASE_LIMIT   = RATE_BITS'(13) << PHASE_FRAC_BITS;
  localparam logic [RATE_BITS-1:0] RATE_STEP_RST = RATE_BITS'(3) << PHASE_FRAC_BITS;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] chan_sample;
    logic                          frame_end;
  } in_req_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] out_sample;
    logic                          run_last;
  } out_req_t;

endpackage

`default_nettype wire

// ----- src/multichannel_peak_pick_linear_resampler.sv -----
// Channel   Ports                          Direction  Carries
// in        in_valid/in_ready/in_data      input      chan_sample, frame_end
// out       out_valid/out_ready/out_data   output     out_sample, run_last
// cfg       cfg_we/cfg_wdata               input      rate_step (Q4.16)
//
// A sample inside a frame, or the first frame end, only updates the picks and
// leaves the block in S_IDLE. A later frame end makes N outputs (N from 0 to 8):
// after the accept, each output takes a multiply (S_LOOP), a round-and-add (S_MUL)
// and an output state (S_OUT) on one shared multiplier, then S_LOOP retires the frame;
// the block holds in_ready low until the frame is retired. A stall on out_ready
// holds that output in S_OUT. Reset (rst_n low, synchronous) clears phase,
// picks and the first-frame flag and sets rate_step to 3.0.
`default_nettype none
`include "assert_macros.svh"

module multichannel_peak_pick_linear_resampler (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire mppr_pkg::in_req_t         in_data,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output mppr_pkg::out_req_t             out_data,
  input  wire logic                      cfg_we,
  input  wire logic [mppr_pkg::RATE_BITS-1:0] cfg_wdata
);
  import mppr_pkg::*;

  localparam int DIFF_BITS = SAMPLE_BITS + 1;
  localparam int PROD_BITS = DIFF_BITS + PHASE_FRAC_BITS + 1;
  localparam int SH_BITS   = PROD_BITS - PHASE_FRAC_BITS;
  localparam logic [PROD_BITS-1:0] HALF = PROD_BITS'(1) << (PHASE_FRAC_BITS - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOOP = 2'd1;
  localparam logic [1:0] S_MUL  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]                   state_r, state_nxt;
  logic [RATE_BITS-1:0]         rate_step_r, rate_step_nxt;
  logic [RATE_BITS-1:0]         phase_r, phase_nxt;
  logic signed [SAMPLE_BITS-1:0] prev_r, prev_nxt;
  logic signed [SAMPLE_BITS-1:0] cur_r, cur_nxt;
  logic                         have_prev_r, have_prev_nxt;
  logic [CNT_BITS-1:0]          cnt_r, cnt_nxt;
  logic signed [PROD_BITS-1:0]  prod_r, prod_nxt;
  logic                         out_valid_r, out_valid_nxt;
  out_req_t                     out_data_r, out_data_nxt;

  logic [RATE_BITS-1:0]         step_c;
  logic [RATE_BITS-1:0]         phase_add;
  logic signed [DIFF_BITS-1:0]  diff;
  logic signed [PHASE_FRAC_BITS:0] frac_s;
  logic [DIFF_BITS-1:0]         mag_in, mag_cur;
  logic signed [SAMPLE_BITS-1:0] pick;
  logic [PROD_BITS-1:0]         rnd;
  logic signed [SH_BITS-1:0]    interp;
  logic                         in_acc;

  // Clamp the step where it is used
  always_comb begin
    if (rate_step_r < STEP_MIN) begin
      step_c = STEP_MIN;
    end else if (rate_step_r > STEP_MAX) begin
      step_c = STEP_MAX;
    end else begin
      step_c = rate_step_r;
    end
  end

  // Peak pick on magnitude: only a strictly larger one replaces
  always_comb begin
    mag_in  = in_data.chan_sample[SAMPLE_BITS-1] ? -DIFF_BITS'(in_data.chan_sample)
                                                  : DIFF_BITS'(in_data.chan_sample);
    mag_cur = cur_r[SAMPLE_BITS-1] ? -DIFF_BITS'(cur_r) : DIFF_BITS'(cur_r);
    pick    = (mag_in > mag_cur) ? in_data.chan_sample : cur_r;
  end

  // Shared datapath: difference, multiply, round and add
  assign diff      = DIFF_BITS'(cur_r) - DIFF_BITS'(prev_r);
  assign frac_s    = signed'({1'b0, phase_r[PHASE_FRAC_BITS-1:0]});
  assign rnd       = prod_r + HALF;
  assign interp    = signed'(rnd[PROD_BITS-1:PHASE_FRAC_BITS]) + SH_BITS'(prev_r);
  assign phase_add = phase_r + step_c;
  assign in_acc    = in_valid && in_ready;

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    rate_step_nxt = cfg_we ? cfg_wdata : rate_step_r;
    phase_nxt     = phase_r;
    prev_nxt      = prev_r;
    cur_nxt       = cur_r;
    have_prev_nxt = have_prev_r;
    cnt_nxt       = cnt_r;
    prod_nxt      = prod_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cur_nxt = pick;
          if (in_data.frame_end) begin
            if (!have_prev_r) begin
              prev_nxt      = pick;
              cur_nxt       = '0;
              have_prev_nxt = 1'b1;
            end else begin
              cnt_nxt   = '0;
              state_nxt = S_LOOP;
            end
          end
        end
      end
      S_LOOP: begin
        if (phase_r < PHASE_ONE && cnt_r < CNT_BITS'(MAX_OUT)) begin
          prod_nxt  = diff * frac_s;
          state_nxt = S_MUL;
        end else begin
          // Drop one frame of phase and retire the pick
          phase_nxt = (phase_r >= PHASE_ONE) ? phase_r - PHASE_ONE : '0;
          prev_nxt  = cur_r;
          cur_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end
      S_MUL: begin
        out_data_nxt.out_sample = interp[SAMPLE_BITS-1:0];
        out_data_nxt.run_last   = (phase_add >= PHASE_ONE) ||
                                  (cnt_r == CNT_BITS'(MAX_OUT - 1));
        out_valid_nxt = 1'b1;
        phase_nxt     = phase_add;
        cnt_nxt       = cnt_r + CNT_BITS'(1);
        state_nxt     = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          state_nxt     = S_LOOP;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rate_step_r <= RATE_STEP_RST;
      phase_r     <= '0;
      prev_r      <= '0;
      cur_r       <= '0;
      have_prev_r <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rate_step_r <= rate_step_nxt;
      phase_r     <= phase_nxt;
      prev_r      <= prev_nxt;
      cur_r       <= cur_nxt;
      have_prev_r <= have_prev_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    prod_r     <= prod_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks
  `ASSERT_NEVER(a_no_overlap, in_ready && out_valid, "input taken while a request is pending")
  `ASSERT_CLK(a_cnt_bound, cnt_r <= CNT_BITS'(MAX_OUT), "more than eight outputs in one frame")
  `ASSERT_CLK(a_phase_bound, phase_r < PHASE_LIMIT, "phase left its range")
  `ASSERT_CLK(a_last_ends, (out_valid && out_ready && out_data.run_last) |-> ##2 in_ready,
    "frame not retired after its last output")

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import mppr_pkg::*;

  localparam int RAND_ITEMS = 310;
  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE_CYCLES = 40;
  localparam int N_DIR = 20;
  localparam longint UNIT = longint'(PHASE_ONE);

  // Receiver stall behavior, reselected whenever the low six bits of cycle_count are zero
  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  // One row of the directed table: optional rate write, then one request
  typedef struct packed {
    logic                          do_cfg;
    logic [RATE_BITS-1:0]          cfg_val;
    in_req_t                       req;
    logic                          typed;
    logic [3:0]                    n_typed;
    logic signed [SAMPLE_BITS-1:0] typed_val;
  } dir_row_t;

  // Rows 0-8 run at the reset step of 3.0, so the outputs are easy to read off
  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    '{1'b0, 20'd0,       '{24'sd100,   1'b0}, 1'b1, 4'd0, 24'sd0},
    '{1'b0, 20'd0,       '{24'h800000, 1'b0}, 1'b1, 4'd0, 24'sd0},
    '{1'b0, 20'd0,       '{24'h7FFFFF, 1'b1}, 1'b1, 4'd0, 24'sd0},
    '{1'b0, 20'd0,       '{24'sd0,     1'b1}, 1'b1, 4'd1, 24'h800000},
    '{1'b0, 20'd0,       '{24'h7FFFFF, 1'b1}, 1'b1, 4'd0, 24'sd0},
    '{1'b0, 20'd0,       '{24'sd5,     1'b0}, 1'b1, 4'd0, 24'sd0},
    '{1'b0, 20'd0,       '{-24'sd5,    1'b0}, 1'b1, 4'd0, 24'sd0},
    '{1'b0, 20'd0,       '{24'sd3,     1'b1}, 1'b1, 4'd0, 24'sd0},
    '{1'b0, 20'd0,       '{-24'sd7,    1'b1}, 1'b1, 4'd1, 24'sd5},
    '{1'b1, 20'd0,       '{24'sd1000,  1'b1}, 1'b0, 4'd0, 24'sd0},
    '{1'b0, 20'd0,       '{-24'sd1000, 1'b1}, 1'b0, 4'd0, 24'sd0},
    '{1'b0, 20'd0,       '{24'h7FFFFF, 1'b1}, 1'b0, 4'd0, 24'sd0},
    '{1'b0, 20'd0,       '{24'h800000, 1'b1}, 1'b0, 4'd0, 24'sd0},
    '{1'b1, 20'd65536,   '{24'sd12345, 1'b1}, 1'b0, 4'd0, 24'sd0},
    '{1'b0, 20'd0,       '{24'sd3,     1'b0}, 1'b0, 4'd0, 24'sd0},
    '{1'b0, 20'd0,       '{24'h800001, 1'b1}, 1'b0, 4'd0, 24'sd0},
    '{1'b1, 20'd786432,  '{24'sd77,    1'b1}, 1'b0, 4'd0, 24'sd0},
    '{1'b1, 20'd1048575, '{24'sd5,     1'b1}, 1'b0, 4'd0, 24'sd0},
    '{1'b1, 20'd8191,    '{24'sd6,     1'b1}, 1'b0, 4'd0, 24'sd0},
    '{1'b1, 20'd786433,  '{-24'sd9,    1'b1}, 1'b0, 4'd0, 24'sd0}
  };

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_req_t              in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_req_t             out_data;
  logic                 cfg_we = 1'b0;
  logic [RATE_BITS-1:0] cfg_wdata = '0;

  // Resampler image: rate register, phase, picks and first-frame flag
  logic [RATE_BITS-1:0] step_reg = RATE_STEP_RST;
  longint               ph_acc = 0;
  longint               last_pick = 0;
  longint               run_pick = 0;
  bit                   seen_frame = 1'b0;

  out_req_t frame_outs [$];
  out_req_t expected_outs [$];
  out_req_t head_out;
  int       mismatches = 0;
  int       cycle_count = 0;
  int       burst_left = 0;
  int       rand_items = 0;
  rx_mode_t rx_mode = RX_OPEN;

  multichannel_peak_pick_linear_resampler dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Track the peak of the frame; on frame end interpolate the outputs
  function automatic void pick_and_interpolate(in_req_t r);
    longint   smp;
    longint   eff_step;
    longint   diff;
    longint   val;
    out_req_t o;
    frame_outs.delete();
    smp = longint'($signed(r.chan_sample));
    if (((smp < 0) ? -smp : smp) > ((run_pick < 0) ? -run_pick : run_pick)) run_pick = smp;
    if (!r.frame_end) return;
    if (!seen_frame) begin
      last_pick = run_pick;
      run_pick = 0;
      seen_frame = 1'b1;
      return;
    end
    eff_step = longint'(step_reg);
    if (eff_step < longint'(STEP_MIN)) eff_step = longint'(STEP_MIN);
    if (eff_step > longint'(STEP_MAX)) eff_step = longint'(STEP_MAX);
    diff = run_pick - last_pick;
    while (ph_acc < UNIT && frame_outs.size() < MAX_OUT) begin
      val = last_pick + ((diff * ph_acc + UNIT / 2) >>> PHASE_FRAC_BITS);
      o.out_sample = SAMPLE_BITS'(val);
      o.run_last = 1'b0;
      frame_outs.push_back(o);
      ph_acc += eff_step;
    end
    if (frame_outs.size() > 0) frame_outs[frame_outs.size() - 1].run_last = 1'b1;
    ph_acc -= UNIT;
    if (ph_acc < 0) ph_acc = 0;
    last_pick = run_pick;
    run_pick = 0;
  endfunction

  // Offer one request in bursts; once taken, queue its expected outputs
  task automatic offer_req(input in_req_t r, input bit typed, input int n_typed,
                           input logic signed [SAMPLE_BITS-1:0] typed_val);
    int       gap;
    out_req_t o;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pick_and_interpolate(r);
    if (typed) begin
      if (n_typed != 0) begin
        o.out_sample = typed_val;
        o.run_last = 1'b1;
        expected_outs.push_back(o);
      end
    end else begin
      foreach (frame_outs[k]) expected_outs.push_back(frame_outs[k]);
    end
  endtask

  // Drain the block, let it settle, then write the rate register
  task automatic write_rate(input logic [RATE_BITS-1:0] v);
    in_valid <= 1'b0;
    while (expected_outs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    step_reg = v;
    burst_left = 0;
  endtask

  // Stall the output side on a pattern of its own
  always @(posedge clk) begin
    if (cycle_count[5:0] == 6'd0) rx_mode <= rx_mode_t'($urandom_range(0, 3));
    case (rx_mode)
      RX_OPEN:   out_ready <= 1'b1;
      RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
      default:   out_ready <= cycle_count[2];
    endcase
  end

  // Compare each taken output with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_outs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected output: out_sample %0d run_last %0b",
                   out_data.out_sample, out_data.run_last);
      end else begin
        head_out = expected_outs.pop_front();
        if (out_data.out_sample !== head_out.out_sample ||
            out_data.run_last !== head_out.run_last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: out_sample exp %0d got %0d, run_last exp %0b got %0b",
                     head_out.out_sample, out_data.out_sample,
                     head_out.run_last, out_data.run_last);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int                            phase_len;
    int                            fed;
    int                            chans;
    logic [RATE_BITS-1:0]          step;
    logic signed [SAMPLE_BITS-1:0] smp;
    in_req_t                       r;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table
    for (int i = 0; i < N_DIR; i++) begin
      if (DIR_ROWS[i].do_cfg) write_rate(DIR_ROWS[i].cfg_val);
      offer_req(DIR_ROWS[i].req, DIR_ROWS[i].typed, int'(DIR_ROWS[i].n_typed),
                DIR_ROWS[i].typed_val);
    end

    // Random phases: pick a step, then stream whole frames
    while (rand_items < RAND_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2: step = RATE_BITS'($urandom_range(8192, 65536));
        3, 4, 5: step = RATE_BITS'($urandom_range(65537, 262144));
        6:       step = STEP_MIN;
        7:       step = STEP_MAX;
        8:       step = RATE_BITS'($urandom_range(0, 8191));
        default: step = RATE_BITS'($urandom_range(786433, 1048575));
      endcase
      write_rate(step);
      phase_len = $urandom_range(12, 40);
      fed = 0;
      while (fed < phase_len) begin
        chans = $urandom_range(1, 8);
        for (int c = 0; c < chans; c++) begin
          case ($urandom_range(0, 7))
            0:       smp = 24'h800000;
            1:       smp = 24'h7FFFFF;
            2:       smp = SAMPLE_BITS'($urandom_range(0, 511)) - 24'sd256;
            default: smp = SAMPLE_BITS'($urandom);
          endcase
          r.chan_sample = smp;
          r.frame_end = (c == chans - 1);
          offer_req(r, 1'b0, 0, 24'sd0);
          fed++;
          rand_items++;
        end
      end
    end

    // Drain and finish
    in_valid <= 1'b0;
    while (expected_outs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_outs.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+src
src/mppr_pkg.sv
src/multichannel_peak_pick_linear_resampler.sv
test/testbench.sv
